// File: hdl/lrr_pkg.sv
`default_nettype none
package lrr_pkg;

    // field widths shared by the channels and the datapath
    localparam int unsigned DATA_W = 32;
    localparam int unsigned RAW_W  = 31;

    // generator constants
    localparam logic [DATA_W-1:0] LCG_MUL   = 32'd1103515245;
    localparam logic [DATA_W-1:0] LCG_INC   = 32'd12345;
    localparam logic [DATA_W-1:0] SEED_INIT = 32'd1;

    // handshake between the sequencer and a shared unit
    typedef struct packed {
        logic start;
    } t_unit_cmd;

    typedef struct packed {
        logic done;
    } t_unit_sts;

endpackage
`default_nettype wire

// File: hdl/lrr_req_if.sv
`default_nettype none
interface lrr_req_if;
    import lrr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] range_min;
    logic signed [DATA_W-1:0] range_max;

    modport source (output valid, output range_min, output range_max, input ready);
    modport sink   (input valid, input range_min, input range_max, output ready);
endinterface
`default_nettype wire

// File: hdl/lrr_rsp_if.sv
`default_nettype none
interface lrr_rsp_if;
    import lrr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value;
    logic        [RAW_W-1:0]  raw_value;
    logic                     span_error;

    modport source (output valid, output value, output raw_value, output span_error,
                     input ready);
    modport sink   (input valid, input value, input raw_value, input span_error,
                     output ready);
endinterface
`default_nettype wire

// File: hdl/lrr_lcg.sv
`default_nettype none
module lrr_lcg (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire lrr_pkg::t_unit_cmd        i_cmd,
    input  wire logic [lrr_pkg::DATA_W-1:0] i_state,
    output lrr_pkg::t_unit_sts             o_sts,
    output logic      [lrr_pkg::DATA_W-1:0] o_next
);
    import lrr_pkg::*;

    logic [DATA_W-1:0] r_prod;
    logic [DATA_W-1:0] r_next;
    logic              r_mul_vld;
    logic              r_done;

    // control: product stage, then add stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_vld <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_mul_vld <= i_cmd.start;
            r_done    <= r_mul_vld;
        end
    end

    // low half of state times multiplier, registered before the add
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_prod <= i_state * LCG_MUL;
        end
        if (r_mul_vld) begin
            r_next <= r_prod + LCG_INC;
        end
    end

    assign o_sts.done = r_done;
    assign o_next     = r_next;

endmodule
`default_nettype wire

// File: hdl/lrr_mod.sv
`default_nettype none
module lrr_mod (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire lrr_pkg::t_unit_cmd         i_cmd,
    input  wire logic [lrr_pkg::RAW_W-1:0]  i_dividend,
    input  wire logic [lrr_pkg::DATA_W-1:0] i_divisor,
    output lrr_pkg::t_unit_sts              o_sts,
    output logic      [lrr_pkg::RAW_W-1:0]  o_rem
);
    import lrr_pkg::*;

    localparam int unsigned CNT_W = $clog2(RAW_W);
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(RAW_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [RAW_W-1:0]  r_dvd;
    logic [DATA_W-1:0] r_dvs;
    logic [RAW_W-1:0]  r_rem;
    logic [DATA_W-1:0] shifted;
    logic [DATA_W-1:0] diff;
    logic              fits;

    // one restoring step: bring down the next dividend bit and try to subtract
    always_comb begin
        shifted = {r_rem, r_dvd[RAW_W-1]};
        diff    = shifted - r_dvs;
        fits    = (shifted >= r_dvs);
    end

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_BIT) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // partial remainder and dividend shift register; remainder stays below the divisor
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[RAW_W-2:0], 1'b0};
            r_rem <= fits ? diff[RAW_W-1:0] : shifted[RAW_W-1:0];
        end
    end

    assign o_sts.done = r_done;
    assign o_rem      = r_rem;

endmodule
`default_nettype wire

// File: hdl/lcg_random_in_range.sv
`default_nettype none
// a request runs three generator steps on the shared unit (multiply then add), then loads the
//   bit-serial remainder unit for 31 remainder steps and finishes; a zero span goes straight to finish
// a new request is taken only once the previous result is registered; a finished result
//   that finds the output full waits
// the output register lets a new request start while a result waits
// reset: synchronous active low, seed and generator state return to 1, no result pending
module lcg_random_in_range (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    lrr_req_if.sink                         i_req,
    lrr_rsp_if.source                       o_rsp,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [2:0]                 paddr,
    input  wire logic [lrr_pkg::DATA_W-1:0] pwdata,
    output logic      [lrr_pkg::DATA_W-1:0] prdata,
    output logic                            pready
);
    import lrr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LCG  = 4'b0010,
        S_DIV  = 4'b0100,
        S_FIN  = 4'b1000
    } t_seq_state;

    localparam logic [1:0] LAST_STEP = 2'd2;

    t_seq_state        r_state, n_state;
    logic [DATA_W-1:0] r_seed;
    logic [DATA_W-1:0] r_gen;
    logic [1:0]        r_step, n_step;
    logic [DATA_W-1:0] r_lo;
    logic [DATA_W-1:0] r_span;
    logic [RAW_W-1:0]  r_raw;
    logic              r_err;
    logic              r_out_vld;
    logic [DATA_W-1:0] r_out_val;
    logic [RAW_W-1:0]  r_out_raw;
    logic              r_out_err;

    t_unit_cmd         lcg_cmd, mod_cmd;
    t_unit_sts         lcg_sts, mod_sts;
    logic [DATA_W-1:0] lcg_next;
    logic [DATA_W-1:0] lcg_src;
    logic [RAW_W-1:0]  mod_rem;
    logic [DATA_W-1:0] span_mag;
    logic              req_xfer;
    logic              cfg_wr;
    logic              out_free;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? r_seed : '0;

    assign i_req.ready = (r_state == S_IDLE);
    assign req_xfer    = i_req.valid && i_req.ready;
    assign out_free    = !r_out_vld || o_rsp.ready;

    // generator step source: live state on a new request, else the last step
    assign lcg_src       = (r_state == S_IDLE) ? r_gen : lcg_next;
    assign span_mag      = r_span[DATA_W-1] ? (DATA_W'(0) - r_span) : r_span;
    assign mod_cmd.start = (r_state == S_LCG) && lcg_sts.done && (r_step == LAST_STEP) &&
                           (r_span != '0);

    // sequencer
    always_comb begin
        n_state       = r_state;
        n_step        = r_step;
        lcg_cmd.start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (req_xfer) begin
                    lcg_cmd.start = 1'b1;
                    n_step        = '0;
                    n_state       = S_LCG;
                end
            end
            S_LCG: begin
                if (lcg_sts.done) begin
                    if (r_step == LAST_STEP) begin
                        n_state = (r_span == '0) ? S_FIN : S_DIV;
                    end else begin
                        lcg_cmd.start = 1'b1;
                        n_step        = r_step + 1'b1;
                    end
                end
            end
            S_DIV: begin
                if (mod_sts.done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_seed  <= SEED_INIT;
            r_gen   <= SEED_INIT;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (cfg_wr) begin
                r_seed <= pwdata;
                r_gen  <= pwdata;
            end else if ((r_state == S_LCG) && lcg_sts.done) begin
                r_gen <= lcg_next;
            end
        end
    end

    // request capture and raw value assembly
    always_ff @(posedge i_clk) begin
        if (req_xfer) begin
            r_lo   <= i_req.range_min;
            r_span <= i_req.range_max - i_req.range_min + DATA_W'(1);
        end
        if ((r_state == S_LCG) && lcg_sts.done) begin
            if (r_step == '0) begin
                r_raw <= {20'd0, lcg_next[26:16]};
            end else begin
                r_raw <= {r_raw[RAW_W-11:0], lcg_next[25:16]};
            end
            r_err <= (r_span == '0);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if ((r_state == S_FIN) && out_free) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_FIN) && out_free) begin
            r_out_val <= r_err ? r_lo : ({1'b0, mod_rem} + r_lo);
            r_out_raw <= r_raw;
            r_out_err <= r_err;
        end
    end

    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.value      = r_out_val;
    assign o_rsp.raw_value  = r_out_raw;
    assign o_rsp.span_error = r_out_err;

    // shared multiply-add unit
    lrr_lcg u_lcg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (lcg_cmd),
        .i_state (lcg_src),
        .o_sts   (lcg_sts),
        .o_next  (lcg_next)
    );

    // bit-serial remainder unit, raw value is the dividend
    lrr_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (mod_cmd),
        .i_dividend ({r_raw[RAW_W-11:0], lcg_next[25:16]}),
        .i_divisor  (span_mag),
        .o_sts      (mod_sts),
        .o_rem      (mod_rem)
    );

    // generator unit reports only while the sequencer waits on it
    a_lcg_done_in_lcg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lcg_sts.done |-> (r_state == S_LCG))
        else $error("generator step finished outside its state");

    // remainder unit reports only while the sequencer waits on it
    a_mod_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_sts.done |-> (r_state == S_DIV))
        else $error("remainder finished outside its state");

    // step counter never passes the third generator step
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != 2'd3))
        else $error("generator step count out of range");

    // a seed write reloads the generator state
    a_seed_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> (r_gen == $past(pwdata)) && (r_seed == $past(pwdata)))
        else $error("seed write did not reload the generator");

endmodule
`default_nettype wire
